@@ rtl/core/palette_learn_and_quantize_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Palette unit assertion macros
// Shared concurrent assertion forms, clocked on clk_i, muted during reset.
// ----------------------------------------------------------------------------
`ifndef PALETTE_LEARN_AND_QUANTIZE_UNIT_DEFINES_SVH
`define PALETTE_LEARN_AND_QUANTIZE_UNIT_DEFINES_SVH

// expression must hold at every edge out of reset
`define PLQ_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// consequent must follow the antecedent (non-overlapping implication)
`define PLQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/plq_pkg.sv @@
// ----------------------------------------------------------------------------
// Palette unit package
// Payload types, register codes, constants and the color distance function.
// ----------------------------------------------------------------------------
package plq_pkg;

  // palette sizing
  localparam int unsigned LEARNED_SLOTS = 15;
  localparam int unsigned SLOT_LIMIT    = (LEARNED_SLOTS < 15) ? LEARNED_SLOTS : 15;
  localparam int unsigned SLOT_DEPTH    = 16;
  localparam int unsigned SLOT_W        = 4;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // color constants
  localparam logic [23:0] DARK_LIMIT     = 24'h080808;
  localparam logic [7:0]  NEAR_THR_RESET = 8'd40;
  localparam int unsigned DIST_W         = 18;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W    = 8;
  localparam logic [7:0]  CFG_BG_COLOR = 8'd0;
  localparam logic [7:0]  CFG_NEAR_THR = 8'd1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LEARN = 2'd1,
    OP_MAP   = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [23:0] pixel_rgb;
  } in_item_t;

  typedef struct packed {
    logic [3:0] color_index;
    logic       added;
    logic [3:0] used_slots;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0]  opcode;
    logic [23:0] pixel_rgb;
    logic        skip;
  } work_t;

  function automatic logic [7:0] plq_abs_diff(input logic [7:0] a, input logic [7:0] b);
    plq_abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  // squared RGB distance, max 3 * 255^2 fits in 18 bits
  function automatic logic [DIST_W-1:0] plq_sq_dist(input logic [23:0] a,
                                                    input logic [23:0] b);
    logic [15:0] dr;
    logic [15:0] dg;
    logic [15:0] db;
    logic [15:0] sr;
    logic [15:0] sg;
    logic [15:0] sb;
    dr = {8'd0, plq_abs_diff(a[23:16], b[23:16])};
    dg = {8'd0, plq_abs_diff(a[15:8], b[15:8])};
    db = {8'd0, plq_abs_diff(a[7:0], b[7:0])};
    sr = dr * dr;
    sg = dg * dg;
    sb = db * db;
    plq_sq_dist = DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
  endfunction

endpackage

@@ rtl/core/plq_fifo.sv @@
// ----------------------------------------------------------------------------
// Palette unit work queue
// Short FIFO of classified items between the front and back parts.
// ----------------------------------------------------------------------------
`include "palette_learn_and_quantize_unit_defines.svh"

module plq_fifo
  import plq_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_en_i,
  input  work_t wr_data_i,
  output logic  full_o,
  input  logic  rd_en_i,
  output work_t rd_data_o,
  output logic  empty_o
);

  work_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_wr;
  logic              do_rd;

  assign full_o    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  `PLQ_ASSERT_ALWAYS(a_fifo_cnt_range, cnt_q <= QCNT_W'(QUEUE_DEPTH), "fifo count overflow")
  `PLQ_ASSERT_NEXT(a_fifo_cnt_inc, do_wr && !do_rd, cnt_q == $past(cnt_q) + 1'b1,
                   "fifo count did not grow on write")
  `PLQ_ASSERT_ALWAYS(a_fifo_ptr_eq, (cnt_q != '0) || (rd_ptr_q == wr_ptr_q),
                     "fifo pointers differ while empty")

endmodule

@@ rtl/core/plq_front.sv @@
// ----------------------------------------------------------------------------
// Palette unit front
// Holds the configuration registers, accepts items and flags skipped pixels.
// ----------------------------------------------------------------------------
module plq_front
  import plq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [23:0]          cfg_data_i,
  // input channel
  input  logic                 push,
  output logic                 full,
  input  in_item_t             in_item_i,
  // queue write side
  output logic                 wr_en_o,
  output work_t                wr_data_o,
  input  logic                 q_full_i
);

  logic [23:0]       bg_q;
  logic [7:0]        thr_q;
  logic [15:0]       thr_sq;
  logic [DIST_W-1:0] bg_dist;
  logic              skip;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q  <= '0;
      thr_q <= NEAR_THR_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BG_COLOR: bg_q  <= cfg_data_i;
        CFG_NEAR_THR: thr_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // skip: near the background or darker than the dark limit
  assign thr_sq  = {8'd0, thr_q} * {8'd0, thr_q};
  assign bg_dist = plq_sq_dist(in_item_i.pixel_rgb, bg_q);
  assign skip    = (bg_dist < DIST_W'(thr_sq)) || (in_item_i.pixel_rgb < DARK_LIMIT);

  // a transfer goes straight into the work queue
  assign full                = q_full_i;
  assign wr_en_o             = push && !q_full_i;
  assign wr_data_o.opcode    = in_item_i.opcode;
  assign wr_data_o.pixel_rgb = in_item_i.pixel_rgb;
  assign wr_data_o.skip      = skip;

endmodule

@@ rtl/core/plq_back.sv @@
// ----------------------------------------------------------------------------
// Palette unit back
// Owns the palette, scans it one slot a cycle and holds the result register.
// ----------------------------------------------------------------------------
`include "palette_learn_and_quantize_unit_defines.svh"

module plq_back
  import plq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  // queue read side
  input  logic      q_empty_i,
  input  work_t     q_data_i,
  output logic      q_pop_o,
  // result channel
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_EMIT = 2'd2
  } back_state_e;

  back_state_e       state_q, state_d;
  work_t             work_q, work_d;
  logic [SLOT_W-1:0] j_q, j_d;
  logic [SLOT_W-1:0] cnt_q, cnt_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [DIST_W-1:0] best_q, best_d;
  out_item_t         res_q, res_d;
  out_item_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic [23:0]       pal_q [SLOT_DEPTH];
  logic              pal_we;
  logic [SLOT_W-1:0] pal_waddr;
  logic [23:0]       rd_slot;
  logic [DIST_W-1:0] slot_dist;
  logic              take;
  logic              match;
  logic              last;

  // slot 0 is black; learned slots come from the register file
  assign rd_slot   = (j_q == '0) ? 24'd0 : pal_q[j_q];
  assign slot_dist = plq_sq_dist(work_q.pixel_rgb, rd_slot);
  assign take      = (j_q == '0) || (slot_dist < best_q);
  assign match     = (j_q <= cnt_q) && (rd_slot == work_q.pixel_rgb);
  assign last      = (j_q >= cnt_q);

  assign empty      = !out_valid_q;
  assign out_item_o = out_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    work_d      = work_q;
    j_d         = j_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    best_d      = best_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    q_pop_o     = 1'b0;
    pal_we      = 1'b0;
    pal_waddr   = cnt_q + 1'b1;

    if (pop && out_valid_q) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          work_d  = q_data_i;
          res_d   = '{color_index: '0, added: 1'b0, used_slots: cnt_q};
          case (q_data_i.opcode)
            OP_CLEAR: begin
              cnt_d            = '0;
              res_d.used_slots = '0;
              state_d          = S_EMIT;
            end
            OP_LEARN: begin
              j_d     = SLOT_W'(1);
              state_d = q_data_i.skip ? S_EMIT : S_SCAN;
            end
            OP_MAP: begin
              j_d     = '0;
              state_d = q_data_i.skip ? S_EMIT : S_SCAN;
            end
            default: state_d = S_EMIT;
          endcase
        end
      end

      S_SCAN: begin
        if (work_q.opcode == OP_LEARN) begin
          // look for the color in slots 1..count, append at the end
          if (match) begin
            state_d = S_EMIT;
          end else if (last) begin
            if (cnt_q < SLOT_W'(SLOT_LIMIT)) begin
              pal_we           = 1'b1;
              cnt_d            = cnt_q + 1'b1;
              res_d.added      = 1'b1;
              res_d.used_slots = cnt_q + 1'b1;
            end
            state_d = S_EMIT;
          end else begin
            j_d = j_q + 1'b1;
          end
        end else begin
          // nearest slot, strict compare keeps the lower index on ties
          if (take) begin
            best_d = slot_dist;
            idx_d  = j_q;
          end
          if (j_q == cnt_q) begin
            res_d.color_index = take ? j_q : idx_q;
            state_d           = S_EMIT;
          end else begin
            j_d = j_q + 1'b1;
          end
        end
      end

      S_EMIT: begin
        if (!out_valid_q || pop) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    j_q    <= j_d;
    idx_q  <= idx_d;
    best_q <= best_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  // palette register file, learned slots only
  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_q[pal_waddr] <= work_q.pixel_rgb;
    end
  end

  `PLQ_ASSERT_ALWAYS(a_cnt_limit, cnt_q <= SLOT_W'(SLOT_LIMIT), "palette count over limit")
  `PLQ_ASSERT_ALWAYS(a_map_scan_range,
                     (state_q != S_SCAN) || (work_q.opcode != OP_MAP) || (j_q <= cnt_q),
                     "map scan past last valid slot")
  `PLQ_ASSERT_NEXT(a_emit_done, (state_q == S_EMIT) && (!out_valid_q || pop),
                   out_valid_q && (state_q == S_IDLE), "result not loaded on emit")
  `PLQ_ASSERT_ALWAYS(a_pop_idle, !q_pop_o || (state_q == S_IDLE), "queue read outside idle")

endmodule

@@ rtl/core/palette_learn_and_quantize_unit.sv @@
// ----------------------------------------------------------------------------
// Palette learn and quantize unit
// Learns a 16-slot RGB palette and maps pixels to nearest-color indices.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive in_item_i and raise push; a transfer happens when full
//   is low. Opcodes: clear palette, learn color, map color to index.
//   Result queue: while empty is low, out_item_o holds the oldest result;
//   raise pop to take it. Every item gives exactly one result.
//   Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i selecting the
//   background color (0) or near threshold (1); write only while idle.
// Timing:
//   The front classifies an item in its accept cycle and queues it (2 deep).
//   The back handles one item at a time: it fetches it, then scans one
//   palette slot per cycle (map: used_slots + 1 slots, learn: up to
//   used_slots, at least 1), then loads the result register. Clear, skipped
//   pixels and unknown opcodes skip the scan and go straight to the load.
// Reset: palette count 0, background black, threshold 40, queues empty.
// Stall: while a result waits, the back holds in its emit step; the front
//   keeps taking items until the work queue is full.
// ----------------------------------------------------------------------------
module palette_learn_and_quantize_unit
  import plq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [23:0]          cfg_data_i,
  // input channel
  input  logic                 push,
  output logic                 full,
  input  in_item_t             in_item_i,
  // result channel
  output logic                 empty,
  input  logic                 pop,
  output out_item_t            out_item_o
);

  logic  wr_en;
  work_t wr_data;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;
  work_t q_data;

  plq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .wr_en_o     (wr_en),
    .wr_data_o   (wr_data),
    .q_full_i    (q_full)
  );

  plq_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_data_i (wr_data),
    .full_o    (q_full),
    .rd_en_i   (q_pop),
    .rd_data_o (q_data),
    .empty_o   (q_empty)
  );

  plq_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_data_i   (q_data),
    .q_pop_o    (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette learn and quantize unit testbench
// Drives clear, learn and map items through the input queue with random gaps
// and pops results with random stalls. A scoreboard class keeps its own copy
// of the palette and the background settings. It predicts one result per
// accepted item and checks every popped result field by field. The run steps
// through several background and threshold settings, the extremes included.
// ----------------------------------------------------------------------------
module tb_top;
  import plq_pkg::*;

  localparam int unsigned CLK_HALF     = 5;
  localparam int unsigned RESET_CYCLES = 5;
  localparam int unsigned ITEMS_PER_PH = 310;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;
  // opcode 3 has no meaning: the block must leave its state alone
  localparam logic [1:0]  OP_UNDEF     = 2'd3;

  // --------------------------------------------------------------------------
  // Palette predictor and result checker
  // --------------------------------------------------------------------------
  class palette_scoreboard;
    logic [23:0]  slots [SLOT_DEPTH];
    int unsigned  learned;
    logic [23:0]  bg_rgb;
    logic [7:0]   near_thr;
    out_item_t    expected_q [$];
    int unsigned  mismatches;

    function new();
      foreach (slots[i]) slots[i] = '0;
      learned    = 0;
      bg_rgb     = '0;
      near_thr   = NEAR_THR_RESET;
      mismatches = 0;
    endfunction

    function void set_reg(logic [7:0] idx, logic [23:0] data);
      if (idx == CFG_BG_COLOR) bg_rgb = data;
      else if (idx == CFG_NEAR_THR) near_thr = data[7:0];
    endfunction

    function int unsigned rgb_dist(logic [23:0] a, logic [23:0] b);
      int dr;
      int dg;
      int db;
      dr = int'(a[23:16]) - int'(b[23:16]);
      dg = int'(a[15:8]) - int'(b[15:8]);
      db = int'(a[7:0]) - int'(b[7:0]);
      return dr * dr + dg * dg + db * db;
    endfunction

    // background-like or too dark to be a real color
    function bit is_transparent(logic [23:0] c);
      int unsigned thr;
      thr = near_thr;
      return (rgb_dist(c, bg_rgb) < thr * thr) || (c < DARK_LIMIT);
    endfunction

    function void note_input(in_item_t it);
      out_item_t   res;
      int unsigned best;
      int unsigned d;
      bit          known;
      res   = '0;
      known = 1'b0;
      case (it.opcode)
        OP_CLEAR: learned = 0;
        OP_LEARN: begin
          if (!is_transparent(it.pixel_rgb)) begin
            for (int j = 1; j <= learned; j++)
              if (slots[j] == it.pixel_rgb) known = 1'b1;
            if (!known && learned < SLOT_LIMIT) begin
              learned++;
              slots[learned] = it.pixel_rgb;
              res.added = 1'b1;
            end
          end
        end
        OP_MAP: begin
          if (!is_transparent(it.pixel_rgb)) begin
            // strict compare keeps the lower slot on a tie
            best = rgb_dist(it.pixel_rgb, slots[0]);
            for (int j = 1; j <= learned; j++) begin
              d = rgb_dist(it.pixel_rgb, slots[j]);
              if (d < best) begin
                best = d;
                res.color_index = 4'(j);
              end
            end
          end
        end
        default: ;
      endcase
      res.used_slots = 4'(learned);
      expected_q.push_back(res);
    endfunction

    function void report(string field, int unsigned exp_v, int unsigned got_v);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, got_v);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: result mismatch, expected none, actual %h", $time, got);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.color_index !== exp_r.color_index)
        report("color_index", exp_r.color_index, got.color_index);
      if (got.added !== exp_r.added)
        report("added", exp_r.added, got.added);
      if (got.used_slots !== exp_r.used_slots)
        report("used_slots", exp_r.used_slots, got.used_slots);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [23:0]          cfg_data_i  = '0;
  logic                 push        = 1'b0;
  logic                 full;
  in_item_t             in_item     = '0;
  logic                 empty;
  logic                 pop         = 1'b1;
  out_item_t            out_item;

  palette_scoreboard    sb;
  bit                   calm = 1'b0;
  logic [23:0]          pool [$];
  int unsigned          hold_cnt = 0;
  int unsigned          quiet_cycles = 0;

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  palette_learn_and_quantize_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item)
  );

  // --------------------------------------------------------------------------
  // Gap lengths: mostly short, a few long, none while calm
  // --------------------------------------------------------------------------
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // result side: pop stalls for a random number of cycles after each transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
        pop      <= (hold_cnt == 1);
      end else if (pop && !empty) begin
        int unsigned g;
        g = idle_len();
        hold_cnt <= g;
        pop      <= (g == 0);
      end
    end
  end

  // transfer monitor feeding the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) sb.note_input(in_item);
      if (pop && !empty) sb.check_result(out_item);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic send(input logic [1:0] op, input logic [23:0] rgb);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= '{opcode: op, pixel_rgb: rgb};
    do @(posedge clk_i); while (full);
  endtask

  // stop pushing and wait until every result is back
  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic configure(input logic [23:0] bg, input logic [7:0] thr);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_BG_COLOR;
    cfg_data_i  <= bg;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(CFG_BG_COLOR, bg);
    cfg_index_i <= CFG_NEAR_THR;
    cfg_data_i  <= {16'd0, thr};
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(CFG_NEAR_THR, {16'd0, thr});
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Pixel sources
  // --------------------------------------------------------------------------
  function automatic logic [7:0] grid_level();
    logic [7:0] lv [5] = '{8'h00, 8'h40, 8'h80, 8'hC0, 8'hFF};
    return lv[$urandom_range(0, 4)];
  endfunction

  // a scene: some random colors, some on a coarse grid so ties come up
  function automatic void new_pool();
    int unsigned n;
    n = $urandom_range(2, 20);
    pool.delete();
    repeat (n) begin
      if ($urandom_range(0, 1) == 0) pool.push_back(24'($urandom));
      else pool.push_back({grid_level(), grid_level(), grid_level()});
    end
  endfunction

  function automatic logic [23:0] nudge(input logic [23:0] c);
    logic [23:0] r;
    int          v;
    for (int k = 0; k < 3; k++) begin
      v = int'(c[8*k +: 8]) + $urandom_range(0, 8) - 4;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      r[8*k +: 8] = 8'(v);
    end
    return r;
  endfunction

  function automatic logic [23:0] pool_pick();
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  function automatic logic [23:0] pick_pixel();
    int unsigned r;
    logic [23:0] a;
    logic [23:0] b;
    r = $urandom_range(0, 99);
    if (r < 35) return pool_pick();
    if (r < 55) return nudge(pool_pick());
    if (r < 65) begin
      // halfway between two scene colors: near-equal distances
      a = pool_pick();
      b = pool_pick();
      for (int k = 0; k < 3; k++)
        a[8*k +: 8] = 8'((int'(a[8*k +: 8]) + int'(b[8*k +: 8])) / 2);
      return a;
    end
    if (r < 80) return 24'($urandom);
    if (r < 88) return nudge(sb.bg_rgb);
    if (r < 94) return 24'($urandom_range(0, DARK_LIMIT - 1));
    case ($urandom_range(0, 3))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      2:       return DARK_LIMIT;
      default: return DARK_LIMIT - 1;
    endcase
  endfunction

  function automatic logic [1:0] noise_op();
    case ($urandom_range(0, 3))
      0:       return OP_CLEAR;
      1:       return OP_LEARN;
      2:       return OP_MAP;
      default: return OP_UNDEF;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Random phase: bursts of learning a scene, then mapping pixels against it
  // --------------------------------------------------------------------------
  task automatic run_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned n_learn;
    int unsigned n_map;
    sent = 0;
    new_pool();
    while (sent < n_items) begin
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 3) == 0) new_pool();
      if ($urandom_range(0, 4) == 0) begin
        send(OP_CLEAR, 24'($urandom));
        sent++;
      end
      n_learn = $urandom_range(1, 20);
      n_map   = $urandom_range(1, 25);
      for (int i = 0; i < n_learn + n_map; i++) begin
        if ($urandom_range(0, 19) == 0) send(noise_op(), 24'($urandom));
        else if (i < n_learn) send(OP_LEARN, pick_pixel());
        else send(OP_MAP, pick_pixel());
        sent++;
      end
    end
    calm = 1'b0;
    settle();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part under reset settings (black background, threshold 40)
    send(OP_MAP,   24'hFFFFFF);            // empty palette: only black
    send(OP_LEARN, 24'h000000);            // background itself, skipped
    send(OP_LEARN, 24'h600000);
    send(OP_LEARN, 24'hA00000);
    send(OP_LEARN, 24'h600000);            // already known
    send(OP_MAP,   24'h800000);            // tie between two slots, lower wins
    send(OP_LEARN, 24'h800000);
    send(OP_MAP,   24'h0A0A0A);            // near background maps to zero
    send(OP_UNDEF, 24'hFFFFFF);
    for (int i = 0; i < 12; i++)
      send(OP_LEARN, {8'(8 + i * 20), 8'hFF, 8'h40});
    send(OP_LEARN, 24'hFFFFFF);            // palette full, dropped
    send(OP_MAP,   24'hFFFFFF);
    send(OP_CLEAR, 24'h123456);
    send(OP_MAP,   24'h800000);            // cleared: back to black
    settle();

    // random part over several settings, extremes included
    configure(24'h000000, 8'd0);
    run_phase(ITEMS_PER_PH);
    configure(24'hFFFFFF, 8'd255);
    run_phase(ITEMS_PER_PH);
    configure(24'($urandom), 8'($urandom));
    run_phase(ITEMS_PER_PH);
    configure(24'h808080, 8'd1);
    run_phase(ITEMS_PER_PH);
    configure(24'($urandom), 8'($urandom_range(0, 64)));
    run_phase(ITEMS_PER_PH);
    configure(24'h000000, NEAR_THR_RESET);
    run_phase(ITEMS_PER_PH);

    // drain, then allow the pipeline time to show stray results
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
